### rtl/core/mmbox_pkg.sv
// Shared types and constants of the mipmap box downsampler.
package mmbox_pkg;

   localparam int CFG_W     = 13;
   localparam int LEVEL_W   = 4;
   localparam int POS_W     = 12;
   localparam int ROW_W     = 12;
   localparam int ROW_LIMIT = 4096;

   typedef enum logic [1:0] {
      CSR_BASE_WIDTH  = 2'd0,
      CSR_BASE_HEIGHT = 2'd1,
      CSR_LEVEL_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CHECK = 4'b0010,
      S_AVG   = 4'b0100,
      S_FLUSH = 4'b1000
   } state_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic [8:0] alpha;
      logic [8:0] blue;
      logic [8:0] green;
      logic [8:0] red;
   } pair_type;

   typedef struct packed {
      pixel_type          pix;
      logic [POS_W-1:0]   pos_y;
      logic [POS_W-1:0]   pos_x;
      logic [LEVEL_W-1:0] level;
   } result_type;

endpackage

### rtl/core/mmbox_line_ram.sv
// Line store of horizontal pair sums, one write and one registered read per cycle.
module mmbox_line_ram
   import mmbox_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  pair_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output pair_type      rd_data_ff
);

   pair_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

### rtl/core/rgba_mipmap_box_downsampler.sv
// Mipmap chain generator: level 0 pass-through and 2x2 box averages for higher levels.
// Each base pixel is taken in the idle state; the block then walks the levels that the
// pixel completes with one shared four-lane adder: a level that stops the walk takes
// only the check step, a level that yields a result takes the check step (line store
// read) and then the average step, and the final result is handed over in the flush
// step. A new pixel is taken only once the block is back in the idle state; with no
// levels at all the pixel yields no result and the block stays idle. The result side
// can stall the average and flush steps.
// Results of one pixel leave in ascending level order, the last one flagged on tlast.
// A write to the width, height or level count register restarts the image.
module rgba_mipmap_box_downsampler
   import mmbox_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_LEVELS = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // red, green, blue, alpha
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // level, pos_x, pos_y, out_red, out_green,
                                     // out_blue, out_alpha, zero fill
   output logic         rsp_tlast,   // last_of_run
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [12:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int LI = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int IW = CW + 2;

   // configuration
   logic [CFG_W-1:0]   width_ff;
   logic [CFG_W-1:0]   height_ff;
   logic [LEVEL_W-1:0] levels_ff;
   logic [WW-1:0]      w_eff;
   logic [CFG_W-1:0]   h_eff;
   logic [LEVEL_W-1:0] nlev;

   // sequencer and datapath state
   state_type          state_ff, state_in;
   logic [LEVEL_W-1:0] lv_ff, lv_in;
   logic [CW-1:0]      cur_x_ff, cur_x_in;
   logic [ROW_W-1:0]   cur_y_ff, cur_y_in;
   pixel_type          cur_v_ff, cur_v_in;
   pair_type           pair_ff, pair_in;
   logic [WW-1:0]      wl_ff, wl_in;
   logic [CFG_W-1:0]   hl_ff, hl_in;
   result_type         held_ff, held_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [CW-1:0]      col_ff [MAX_LEVELS];
   logic [ROW_W-1:0]   row_ff [MAX_LEVELS];
   pixel_type          pend_ff [MAX_LEVELS];

   logic               accept;
   logic               can_push;
   logic               push;
   logic               push_last;

   // counter advance
   logic               adv_en;
   logic [LI-1:0]      adv_idx;
   logic [WW-1:0]      adv_w;
   logic [CFG_W-1:0]   adv_h;
   logic [WW-1:0]      col_next;
   logic [CFG_W-1:0]   row_next;

   // level check
   logic [WW-1:0]      wl;
   logic [CFG_W-1:0]   hl;
   logic               stop;
   logic [IW-1:0]      line_idx;
   logic               pend_we;

   // shared adder
   logic [9:0]         sum_r, sum_g, sum_b, sum_a;
   logic [8:0]         op_a_r, op_a_g, op_a_b, op_a_a;
   logic [8:0]         op_b_r, op_b_g, op_b_b, op_b_a;
   pixel_type          avg_pix;

   // line store
   logic               ram_we;
   logic               ram_re;
   pair_type           ram_rd;

   always_comb begin
      w_eff = WW'(width_ff);
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (WW'(width_ff) > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end
      h_eff = height_ff;
      if (height_ff == '0) begin
         h_eff = CFG_W'(1);
      end else if (height_ff > CFG_W'(ROW_LIMIT)) begin
         h_eff = CFG_W'(ROW_LIMIT);
      end
      nlev = (levels_ff > LEVEL_W'(MAX_LEVELS)) ? LEVEL_W'(MAX_LEVELS) : levels_ff;
   end

   assign accept   = req_tvalid && req_tready;
   assign can_push = !rsp_valid_ff || rsp_tready;

   // One adder serves both the pair sum and the final four-pixel sum.
   always_comb begin
      if (state_ff == S_AVG) begin
         op_a_r = ram_rd.red;   op_b_r = pair_ff.red;
         op_a_g = ram_rd.green; op_b_g = pair_ff.green;
         op_a_b = ram_rd.blue;  op_b_b = pair_ff.blue;
         op_a_a = ram_rd.alpha; op_b_a = pair_ff.alpha;
      end else begin
         op_a_r = 9'(pend_ff[LI'(lv_ff)].red);   op_b_r = 9'(cur_v_ff.red);
         op_a_g = 9'(pend_ff[LI'(lv_ff)].green); op_b_g = 9'(cur_v_ff.green);
         op_a_b = 9'(pend_ff[LI'(lv_ff)].blue);  op_b_b = 9'(cur_v_ff.blue);
         op_a_a = 9'(pend_ff[LI'(lv_ff)].alpha); op_b_a = 9'(cur_v_ff.alpha);
      end
      sum_r = 10'(op_a_r) + 10'(op_b_r);
      sum_g = 10'(op_a_g) + 10'(op_b_g);
      sum_b = 10'(op_a_b) + 10'(op_b_b);
      sum_a = 10'(op_a_a) + 10'(op_b_a);
      avg_pix.red   = sum_r[9:2];
      avg_pix.green = sum_g[9:2];
      avg_pix.blue  = sum_b[9:2];
      avg_pix.alpha = sum_a[9:2];
   end

   always_comb begin
      wl = w_eff >> lv_ff;
      hl = h_eff >> lv_ff;
      stop = (wl == '0) || (hl == '0) || (WW'(cur_x_ff >> 1) >= wl)
          || (CFG_W'(cur_y_ff >> 1) >= hl);
      line_idx = IW'(MAX_WIDTH) - (IW'(MAX_WIDTH) >> (lv_ff - LEVEL_W'(1)))
               + IW'(cur_x_ff >> 1);
   end

   always_comb begin
      state_in     = state_ff;
      lv_in        = lv_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_v_in     = cur_v_ff;
      pair_in      = pair_ff;
      wl_in        = wl_ff;
      hl_in        = hl_ff;
      held_in      = held_ff;
      push         = 1'b0;
      push_last    = 1'b0;
      adv_en       = 1'b0;
      adv_idx      = LI'(lv_ff);
      adv_w        = wl_ff;
      adv_h        = hl_ff;
      pend_we      = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      req_tready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            adv_idx    = '0;
            adv_w      = w_eff;
            adv_h      = h_eff;
            if (accept) begin
               adv_en        = 1'b1;
               cur_x_in      = col_ff[0];
               cur_y_in      = row_ff[0];
               cur_v_in      = pixel_type'(req_tdata);
               lv_in         = LEVEL_W'(1);
               held_in.level = '0;
               held_in.pos_x = POS_W'(col_ff[0]);
               held_in.pos_y = row_ff[0];
               held_in.pix   = pixel_type'(req_tdata);
               if (nlev == '0) begin
                  state_in = S_IDLE;
               end else if (nlev == LEVEL_W'(1)) begin
                  state_in = S_FLUSH;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            pair_in.red   = sum_r[8:0];
            pair_in.green = sum_g[8:0];
            pair_in.blue  = sum_b[8:0];
            pair_in.alpha = sum_a[8:0];
            wl_in         = wl;
            hl_in         = hl;
            state_in      = S_FLUSH;
            if (!stop) begin
               if (!cur_x_ff[0]) begin
                  pend_we = 1'b1;
               end else if (line_idx < IW'(MAX_WIDTH)) begin
                  if (!cur_y_ff[0]) begin
                     ram_we = 1'b1;
                  end else begin
                     ram_re   = 1'b1;
                     state_in = S_AVG;
                  end
               end
            end
         end
         S_AVG: begin
            if (can_push) begin
               push          = 1'b1;
               adv_en        = 1'b1;
               held_in.level = lv_ff;
               held_in.pos_x = POS_W'(col_ff[LI'(lv_ff)]);
               held_in.pos_y = row_ff[LI'(lv_ff)];
               held_in.pix   = avg_pix;
               cur_x_in      = col_ff[LI'(lv_ff)];
               cur_y_in      = row_ff[LI'(lv_ff)];
               cur_v_in      = avg_pix;
               lv_in         = lv_ff + LEVEL_W'(1);
               state_in      = ((lv_ff + LEVEL_W'(1)) >= nlev) ? S_FLUSH : S_CHECK;
            end
         end
         S_FLUSH: begin
            if (can_push) begin
               push      = 1'b1;
               push_last = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      col_next = WW'(col_ff[adv_idx]) + WW'(1);
      row_next = CFG_W'(row_ff[adv_idx]) + CFG_W'(1);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = held_ff;
         rsp_last_in  = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lv_ff        <= '0;
         width_ff     <= CFG_W'(4096);
         height_ff    <= CFG_W'(4096);
         levels_ff    <= LEVEL_W'(12);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lv_ff        <= lv_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_WIDTH:  width_ff  <= csr_wdata;
               CSR_BASE_HEIGHT: height_ff <= csr_wdata;
               CSR_LEVEL_COUNT: levels_ff <= csr_wdata[LEVEL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Position counters; a write to a known register restarts the image.
   always_ff @(posedge clock) begin
      if (reset || (csr_we && (csr_index == CSR_BASE_WIDTH || csr_index == CSR_BASE_HEIGHT
                               || csr_index == CSR_LEVEL_COUNT))) begin
         for (int i = 0; i < MAX_LEVELS; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
         end
      end else if (adv_en) begin
         if (col_next >= adv_w) begin
            col_ff[adv_idx] <= '0;
            row_ff[adv_idx] <= (row_next >= adv_h) ? '0 : ROW_W'(row_next);
         end else begin
            col_ff[adv_idx] <= CW'(col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      cur_v_ff    <= cur_v_in;
      pair_ff     <= pair_in;
      wl_ff       <= wl_in;
      hl_ff       <= hl_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (pend_we) begin
         pend_ff[LI'(lv_ff)] <= cur_v_ff;
      end
   end

   mmbox_line_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (line_idx[CW-1:0]),
      .wr_data    (pair_in),
      .rd_en      (ram_re),
      .rd_addr    (line_idx[CW-1:0]),
      .rd_data_ff (ram_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

   // A word with at least one level always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && nlev != '0) |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after a word with results");

   // Averaging only ever happens for a level above the base and below the count.
   a_avg_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AVG) |-> (lv_ff != '0 && lv_ff < nlev))
      else $error("average step on an invalid level");

   // The average step follows a line read issued by the check step.
   a_avg_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AVG && $past(state_ff) != S_AVG) |-> $past(ram_re))
      else $error("average step without a line store read");

   // The last result of a word is handed over only on the way back to idle.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (push && push_last) |=> (state_ff == S_IDLE))
      else $error("last result pushed without returning to idle");

endmodule

### bench/tb.sv
// Self-checking testbench for the mipmap box downsampler, with its own model of the chain.
module tb
   import mmbox_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W        = 4096;
   localparam int MAX_LV       = 12;
   localparam int DRAIN_CYCLES = 64;
   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic       last;
      pixel_type  pix;
      logic [11:0] pos_y;
      logic [11:0] pos_x;
      logic [3:0]  level;
   } mip_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // red, green, blue, alpha
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // level, pos_x, pos_y, out_red, out_green,
                                  // out_blue, out_alpha, zero fill
   logic        rsp_tlast;        // last_of_run
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_wdata = '0;

   rgba_mipmap_box_downsampler dut (.*);

   always #10 clock = ~clock;

   // Model state
   int unsigned   cfg_width = 4096, cfg_height = 4096, cfg_levels = 12;
   int unsigned   col_at[MAX_LV], row_at[MAX_LV];
   int unsigned   left_px[MAX_LV][4];
   int unsigned   pair_line[MAX_W][4];
   mip_pixel_type expected_pixels[$];

   int src_idle = 0, snk_idle = 0;
   int hold_ask = 0, hold_seen = 0, hold_left = 0;
   int fails = 0, quiet_cycles = 0;

   task automatic restart_image();
      for (int i = 0; i < MAX_LV; i++) begin
         col_at[i] = 0;
         row_at[i] = 0;
      end
   endtask

   task automatic step_position(int lv, int unsigned w, int unsigned h);
      col_at[lv]++;
      if (col_at[lv] >= w) begin
         col_at[lv] = 0;
         row_at[lv]++;
         if (row_at[lv] >= h) row_at[lv] = 0;
      end
   endtask

   function automatic mip_pixel_type make_pixel(int lv, int unsigned x, int unsigned y,
                                                int unsigned c[4]);
      mip_pixel_type r;
      r.level = 4'(lv);
      r.pos_x = 12'(x);
      r.pos_y = 12'(y);
      r.pix = {c[3][7:0], c[2][7:0], c[1][7:0], c[0][7:0]};
      r.last = 1'b0;
      return r;
   endfunction

   // Works out the chain of averages that one base pixel completes.
   task automatic predict_chain(pixel_type p);
      int unsigned w, h, nlev, x, y, wl, hl, idx;
      int unsigned c[4], pr[4];
      mip_pixel_type run[$];
      w = (cfg_width == 0) ? 1 : (cfg_width > MAX_W ? MAX_W : cfg_width);
      h = (cfg_height == 0) ? 1 : (cfg_height > ROW_LIMIT ? ROW_LIMIT : cfg_height);
      nlev = (cfg_levels > MAX_LV) ? MAX_LV : cfg_levels;
      c = '{p.red, p.green, p.blue, p.alpha};
      x = col_at[0];
      y = row_at[0];
      step_position(0, w, h);
      if (nlev == 0) return;
      run.push_back(make_pixel(0, x, y, c));
      for (int lv = 1; lv < nlev; lv++) begin
         wl = w >> lv;
         hl = h >> lv;
         if (wl == 0 || hl == 0) break;
         if ((x >> 1) >= wl || (y >> 1) >= hl) break;
         if (!x[0]) begin
            left_px[lv] = c;
            break;
         end
         for (int k = 0; k < 4; k++) pr[k] = left_px[lv][k] + c[k];
         idx = MAX_W - (MAX_W >> (lv - 1)) + (x >> 1);
         if (idx >= MAX_W) break;
         if (!y[0]) begin
            pair_line[idx] = pr;
            break;
         end
         for (int k = 0; k < 4; k++) c[k] = ((pair_line[idx][k] + pr[k]) >> 2) & 8'hFF;
         x = col_at[lv];
         y = row_at[lv];
         step_position(lv, wl, hl);
         run.push_back(make_pixel(lv, x, y, c));
      end
      run[run.size() - 1].last = 1'b1;
      foreach (run[i]) expected_pixels.push_back(run[i]);
   endtask

   // Offers one pixel; valid stays high into the next word unless the sender idles.
   task automatic send_pixel(pixel_type p);
      if ($urandom_range(99) < src_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata <= p;
      do @(posedge clock); while (!req_tready);
      predict_chain(p);
   endtask

   task automatic send_random(int n);
      repeat (n) send_pixel($urandom);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [12:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BASE_WIDTH: begin
            cfg_width = value;
            restart_image();
         end
         CSR_BASE_HEIGHT: begin
            cfg_height = value;
            restart_image();
         end
         CSR_LEVEL_COUNT: begin
            cfg_levels = value[3:0];
            restart_image();
         end
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_image(int w, int h, int lv);
      wait_idle();
      write_reg(CSR_BASE_WIDTH, 13'(w));
      write_reg(CSR_BASE_HEIGHT, 13'(h));
      write_reg(CSR_LEVEL_COUNT, 13'(lv));
   endtask

   task automatic test_channel_extremes();
      set_image(4, 4, 12);
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h55AA_55AA);
      send_pixel(32'hAA55_AA55);
      send_random(8);
   endtask

   task automatic test_register_extremes();
      // Oversized width and zero height clamp to a single full-width row.
      set_image(8191, 0, 15);
      send_random(3);
      set_image(0, 8191, 12);
      send_random(3);
      set_image(4096, 4096, 1);
      send_random(2);
      // No levels at all: pixels are swallowed without any word out.
      set_image(2, 2, 0);
      send_random(3);
      // An unknown index must not restart the image.
      set_image(4, 2, 3);
      send_random(3);
      wait_idle();
      write_reg(CSR_UNUSED, 13'h1FFF);
      send_random(5);
   endtask

   task automatic test_backpressure();
      set_image(6, 4, 12);
      hold_ask++;
      send_random(24);
   endtask

   task automatic test_random_images();
      int sent;
      int extra;
      int w, h, lv;
      int modes[4][2] = '{'{0, 0}, '{68, 0}, '{0, 68}, '{7, 7}};
      for (int m = 0; m < 4; m++) begin
         sent = 0;
         while (sent < 20) begin
            w = ($urandom_range(9) == 0) ? 16 : $urandom_range(1, 9);
            h = $urandom_range(1, 8);
            lv = ($urandom_range(5) == 0) ? $urandom_range(0, 15) : 12;
            set_image(w, h, lv);
            src_idle = modes[m][0];
            snk_idle = modes[m][1];
            send_random(w * h);
            sent += w * h;
            if ($urandom_range(3) == 0) begin
               extra = $urandom_range(1, w * h);
               send_random(extra);
               sent += extra;
            end
         end
      end
      src_idle = 0;
      snk_idle = 0;
   endtask

   function automatic void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
         $error("%s: expected %0d, got %0d", name, exp, act);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result word %h", rsp_tdata);
            fails++;
         end else begin
            mip_pixel_type e;
            result_type a;
            e = expected_pixels.pop_front();
            a = rsp_tdata[59:0];
            check_field("level", e.level, a.level);
            check_field("pos_x", e.pos_x, a.pos_x);
            check_field("pos_y", e.pos_y, a.pos_y);
            check_field("out_red", e.pix.red, a.pix.red);
            check_field("out_green", e.pix.green, a.pix.green);
            check_field("out_blue", e.pix.blue, a.pix.blue);
            check_field("out_alpha", e.pix.alpha, a.pix.alpha);
            check_field("zero_fill", 0, rsp_tdata[63:60]);
            check_field("last_of_run", e.last, rsp_tlast);
         end
      end
   end

   // Result side: random stalls, plus a long hold-off when a test asks for one.
   always @(posedge clock) begin
      if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= snk_idle);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      restart_image();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_channel_extremes();
      test_register_extremes();
      test_backpressure();
      test_random_images();
      wait_idle();
      if (fails == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
